[hdl/mqsj_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the multi-line shortest-job server.
// No dependencies; imported by the top level, the checker and the testbench.
package mqsj_pkg;

    localparam int CLK_W     = 40;
    localparam int ARR_W     = 30;
    localparam int TIX_W     = 10;
    localparam int LINE_W    = 4;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int BASE_W    = 16;
    localparam int PTT_W     = 8;
    localparam int PROD_W    = PTT_W + TIX_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SERVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLR   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PTT  = 1'd1;

    localparam logic [BASE_W-1:0] BASE_RESET = 16'd20;
    localparam logic [PTT_W-1:0]  PTT_RESET  = 8'd10;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ARR_W-1:0]  arrival_time;
        logic [LINE_W-1:0] line_number;
        logic [TIX_W-1:0]  ticket_count;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LINE_W-1:0] served_line;
        logic [CLK_W-1:0]  leave_time;
    } t_out_item;

    // one stored job: tickets on top, arrival below
    typedef struct packed {
        logic [TIX_W-1:0] ticket_count;
        logic [ARR_W-1:0] arrival_time;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

[hdl/mqsj_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mqsj_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 768,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/multi_queue_shortest_job_server.sv]
`timescale 1ns / 1ps
// Top level of the multi-line shortest-job server: sequencer, line pointers,
// shared scan comparator and leave-time arithmetic. Uses mqsj_pkg, mqsj_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request per
//   transaction: enqueue, serve or clock reset. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one result per request.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 base service time, 1 per-ticket time); write only while idle.
// Steps from the accepting edge to the edge that loads the result: a clock
//   reset or unused code goes straight to the result; an enqueue goes through
//   its write step; a serve scans all lines for the earliest head, ends if all
//   are empty, scans again for the fewest tickets unless that head arrives at
//   or after the clock, then multiplies and adds. The head scan reads one line
//   per cycle through the single read port of the job RAM, once per pass.
//   o_in_ready is high from the loading edge, so the next request is taken in the next cycle at the earliest.
// One request is in flight at a time. A finished result sits in the output
// register; a new request is taken while it waits, and a stalled receiver
// holds the block in its final step only when a second result is ready.
// Reset clears all lines, the service clock and the output valid flag, and
// loads the configuration defaults (20 and 10). Job RAM is not cleared.
module multi_queue_shortest_job_server
    import mqsj_pkg::*;
#(
    parameter int NUM_LINES  = 12,
    parameter int LINE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SW    = $clog2(LINE_DEPTH);
    localparam int CW    = $clog2(LINE_DEPTH + 1);
    localparam int DEPTH = NUM_LINES * LINE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LW-1:0] LAST_LINE = LW'(NUM_LINES - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ENQ    = 8'b0000_0010,
        S_SCAN1  = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_SCAN2  = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_ADD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    function automatic logic [AW-1:0] job_addr(input logic [LW-1:0] ln,
                                               input logic [SW-1:0] slot);
        return AW'(ln) * AW'(LINE_DEPTH) + AW'(slot);
    endfunction

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] slot);
        return (slot == SW'(LINE_DEPTH - 1)) ? '0 : slot + SW'(1);
    endfunction

    t_state            r_state, n_state;
    t_in_item          r_req;
    logic [LW-1:0]     r_line;
    logic              r_bad;
    logic [SW-1:0]     r_head [NUM_LINES];
    logic [SW-1:0]     r_tail [NUM_LINES];
    logic [CW-1:0]     r_cnt  [NUM_LINES];
    logic [CLK_W-1:0]  r_clock;
    logic [BASE_W-1:0] r_base;
    logic [PTT_W-1:0]  r_ptt;
    // scan pipeline: issue RAM read, compare in the next cycle
    logic [LW-1:0]     r_idx;
    logic              r_issue_done;
    logic              r_p_vld;
    logic              r_p_nz;
    logic [LW-1:0]     r_p_line;
    logic              r_any;
    logic [ARR_W-1:0]  r_best_arr;
    logic [LW-1:0]     r_best_line;
    logic [TIX_W-1:0]  r_best_tix;
    logic [PROD_W-1:0] r_prod;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              w_accept;
    logic              w_scan;
    logic              w_scan2;
    logic [LW-1:0]     w_sel;
    logic [SW-1:0]     w_head;
    logic [SW-1:0]     w_tail;
    logic [CW-1:0]     w_cnt;
    logic              w_full;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    t_job              w_wjob;
    logic [JOB_W-1:0]  w_rdata;
    t_job              w_job;
    logic [ARR_W-1:0]  w_key;
    logic [ARR_W-1:0]  w_best_key;
    logic              w_arrived;
    logic              w_take;
    logic              w_scan_end;
    logic              w_due;
    logic [CLK_W+1:0]  w_sum;
    logic [CLK_W-1:0]  w_lt;
    logic [LW:0]       w_sline;
    logic              w_load;
    logic              w_enq_bad;
    logic [5:0]        w_ln;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_scan   = (r_state == S_SCAN1) || (r_state == S_SCAN2);
    assign w_scan2  = (r_state == S_SCAN2);

    // one shared line select for all pointer reads and writes
    always_comb begin
        if (w_scan) begin
            w_sel = r_idx;
        end else if (r_state == S_ENQ) begin
            w_sel = r_line;
        end else begin
            w_sel = r_best_line;
        end
    end

    assign w_head = r_head[w_sel];
    assign w_tail = r_tail[w_sel];
    assign w_cnt  = r_cnt[w_sel];
    assign w_full = (w_cnt == CW'(LINE_DEPTH));

    assign w_wjob.ticket_count = r_req.ticket_count;
    assign w_wjob.arrival_time = r_req.arrival_time;
    assign w_we    = (r_state == S_ENQ) && !r_bad && !w_full;
    assign w_waddr = job_addr(r_line, w_tail);
    assign w_raddr = job_addr(r_idx, w_head);

    mqsj_ram #(
        .WIDTH (JOB_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_jobs (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wjob),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_job = t_job'(w_rdata);

    // shared comparator: arrival in the first pass, tickets in the second
    assign w_key      = w_scan2 ? ARR_W'(w_job.ticket_count) : w_job.arrival_time;
    assign w_best_key = w_scan2 ? ARR_W'(r_best_tix) : r_best_arr;
    assign w_arrived  = (CLK_W'(w_job.arrival_time) <= r_clock);
    assign w_take     = r_p_vld && r_p_nz && (!w_scan2 || w_arrived)
                        && (!r_any || (w_key < w_best_key));
    assign w_scan_end = r_issue_done && r_p_vld;
    assign w_due      = (CLK_W'(r_best_arr) >= r_clock);

    assign w_sum = (CLK_W + 2)'(r_clock) + (CLK_W + 2)'(r_base)
                   + (CLK_W + 2)'(r_prod);
    assign w_lt  = (|w_sum[CLK_W+1:CLK_W]) ? '1 : w_sum[CLK_W-1:0];
    assign w_sline = {1'b0, r_best_line} + (LW + 1)'(1);

    assign w_ln      = 6'(i_in_data.line_number);
    assign w_enq_bad = (w_ln == 6'd0) || (w_ln > 6'(NUM_LINES));

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_in_data.req_type == REQ_ENQ) begin
                        n_state = S_ENQ;
                    end else if (i_in_data.req_type == REQ_SERVE) begin
                        n_state = S_SCAN1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ENQ:   n_state = S_DONE;
            S_SCAN1: begin
                if (w_scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (!r_any) begin
                    n_state = S_DONE;
                end else if (w_due) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SCAN2;
                end
            end
            S_SCAN2: begin
                if (w_scan_end) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_clock      <= '0;
            r_base       <= BASE_RESET;
            r_ptt        <= PTT_RESET;
            r_issue_done <= 1'b0;
            r_p_vld      <= 1'b0;
            r_any        <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE: r_base <= i_cfg_wdata[BASE_W-1:0];
                    CFG_PTT:  r_ptt  <= i_cfg_wdata[PTT_W-1:0];
                    default:  ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                r_issue_done <= 1'b0;
                r_p_vld      <= 1'b0;
                r_any        <= 1'b0;
                if (i_in_data.req_type == REQ_CLR) begin
                    r_clock <= '0;
                end
            end

            if (w_scan) begin
                if (!r_issue_done) begin
                    r_p_vld <= 1'b1;
                    if (r_idx == LAST_LINE) begin
                        r_issue_done <= 1'b1;
                    end
                end else begin
                    r_p_vld <= 1'b0;
                end
                if (w_take) begin
                    r_any <= 1'b1;
                end
            end

            if (r_state == S_DECIDE) begin
                r_issue_done <= 1'b0;
                r_p_vld      <= 1'b0;
                r_any        <= 1'b0;
                if (r_any && w_due) begin
                    r_clock <= CLK_W'(r_best_arr);
                end
            end

            if (w_we) begin
                r_tail[w_sel] <= next_slot(w_tail);
                r_cnt[w_sel]  <= w_cnt + CW'(1);
            end

            if (r_state == S_ADD) begin
                r_clock       <= w_lt;
                r_head[w_sel] <= next_slot(w_head);
                r_cnt[w_sel]  <= w_cnt - CW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_in_data;
            r_line <= LW'(w_ln - 6'd1);
            r_bad  <= w_enq_bad;
            r_idx  <= '0;
            r_res  <= '{status: ST_DONE, served_line: '0, leave_time: '0};
        end

        if (w_scan && !r_issue_done) begin
            r_p_nz   <= (w_cnt != '0);
            r_p_line <= r_idx;
            if (r_idx != LAST_LINE) begin
                r_idx <= r_idx + LW'(1);
            end
        end

        if (w_scan && w_take) begin
            r_best_tix  <= w_job.ticket_count;
            r_best_line <= r_p_line;
            if (!w_scan2) begin
                r_best_arr <= w_job.arrival_time;
            end
        end

        if (r_state == S_DECIDE) begin
            r_idx <= '0;
            if (!r_any) begin
                r_res <= '{status: ST_EMPTY, served_line: '0, leave_time: '0};
            end
        end

        if (r_state == S_ENQ) begin
            r_res <= '{status: (r_bad || w_full) ? ST_FULL : ST_DONE,
                       served_line: '0, leave_time: '0};
        end

        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_ptt) * PROD_W'(r_best_tix);
        end

        if (r_state == S_ADD) begin
            r_res <= '{status: ST_DONE, served_line: LINE_W'(w_sline),
                       leave_time: w_lt};
        end

        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/mqsj_check.sv]
`timescale 1ns / 1ps
// Port-level checker for the multi-line shortest-job server, bound to the top.
// Uses mqsj_pkg; attached by the bind statement at the end of this file.
module mqsj_check
    import mqsj_pkg::*;
#(
    parameter int NUM_LINES = 12
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a result waiting for the receiver keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction dropped or changed while stalled");

    // one request in flight: busy right after each accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    // a new result is loaded exactly as the block turns idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result loaded without returning to idle");

    // only a completed serve names a line, and it is a real line
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.served_line <= NUM_LINES)
            && (o_out_data.status == ST_DONE || o_out_data.served_line == '0))
        else $error("served line out of range or given with a failure status");

    // failures carry no leave time; status code is a defined one
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_DONE
            || ((o_out_data.status == ST_EMPTY || o_out_data.status == ST_FULL)
                && o_out_data.leave_time == '0)))
        else $error("bad status code or leave time on a failed request");

endmodule

bind multi_queue_shortest_job_server mqsj_check #(
    .NUM_LINES(NUM_LINES)
) u_mqsj_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

[sim/multi_queue_shortest_job_server_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the multi-line shortest-job server: directed
// corners, a full line, output backpressure and random traffic under three
// idle mixes. Depends on mqsj_pkg and multi_queue_shortest_job_server.
module multi_queue_shortest_job_server_test;
    import mqsj_pkg::*;

    localparam int NUM_LINES    = 12;
    localparam int LINE_DEPTH   = 64;
    localparam int STALL_CYCLES = 400;
    localparam int MAX_REPORTS  = 100;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [ARR_W-1:0] ARR_MAX    = {ARR_W{1'b1}};
    localparam logic [TIX_W-1:0] TIX_MAX    = {TIX_W{1'b1}};
    localparam logic [63:0]      CLK_SAT    = {24'd0, {CLK_W{1'b1}}};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    // predicted scheduler state
    t_job              job_ring [NUM_LINES][LINE_DEPTH];
    int                ring_head [NUM_LINES];
    int                ring_count [NUM_LINES];
    logic [CLK_W-1:0]  sched_clock    = '0;
    logic [BASE_W-1:0] cfg_base       = BASE_RESET;
    logic [PTT_W-1:0]  cfg_per_ticket = PTT_RESET;
    t_out_item         pending_outcomes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_req     = 1'b0;
    int n_errors      = 0;
    int n_requests    = 0;
    int n_results     = 0;
    int n_served      = 0;
    int n_empty       = 0;
    int n_rejected    = 0;
    int n_jumps       = 0;
    int n_shortest    = 0;
    int n_settings    = 0;

    multi_queue_shortest_job_server #(
        .NUM_LINES  (NUM_LINES),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("** multi_queue_shortest_job_server: FAILED **");
        $finish;
    end

    // receiver: random ready, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result checker: every transaction on the output is matched in order
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_outcomes.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, actual %p",
                             $time, o_out_data);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_out_data.status == ST_DONE && o_out_data.served_line != 0)
                        n_served++;
                    if (o_out_data.status == ST_EMPTY) n_empty++;
                    if (o_out_data.status == ST_FULL) n_rejected++;
                    if (o_out_data.status !== want.status) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: status mismatch: expected %0d, actual %0d",
                                     $time, want.status, o_out_data.status);
                    end
                    if (o_out_data.served_line !== want.served_line) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: served_line mismatch: expected %0d, actual %0d",
                                     $time, want.served_line, o_out_data.served_line);
                    end
                    if (o_out_data.leave_time !== want.leave_time) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: leave_time mismatch: expected %0d, actual %0d",
                                     $time, want.leave_time, o_out_data.leave_time);
                    end
                end
            end
        end
    end

    // Works out the result of one accepted request and updates the state.
    task automatic predict_outcome(input t_in_item req);
        t_out_item        res;
        t_job             job;
        int               ln;
        int               best;
        int               pick;
        bit               found;
        logic [ARR_W-1:0] best_arr;
        logic [TIX_W-1:0] least;
        logic [63:0]      total;
        res      = '0;
        best     = -1;
        pick     = 0;
        found    = 1'b0;
        best_arr = '0;
        least    = '0;
        case (req.req_type)
            REQ_ENQ: begin
                ln = int'(req.line_number);
                if (ln < 1 || ln > NUM_LINES) begin
                    res.status = ST_FULL;
                end else if (ring_count[ln-1] >= LINE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    job.arrival_time = req.arrival_time;
                    job.ticket_count = req.ticket_count;
                    job_ring[ln-1][(ring_head[ln-1] + ring_count[ln-1]) % LINE_DEPTH] = job;
                    ring_count[ln-1]++;
                end
            end
            REQ_SERVE: begin
                for (int i = 0; i < NUM_LINES; i++) begin
                    if (ring_count[i] != 0 &&
                        (best < 0 || job_ring[i][ring_head[i]].arrival_time < best_arr)) begin
                        best_arr = job_ring[i][ring_head[i]].arrival_time;
                        best     = i;
                    end
                end
                if (best < 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (best_arr >= sched_clock) begin
                        // nothing due yet: idle until the earliest arrival
                        sched_clock = best_arr;
                        pick = best;
                        n_jumps++;
                    end else begin
                        for (int i = 0; i < NUM_LINES; i++) begin
                            if (ring_count[i] != 0 &&
                                job_ring[i][ring_head[i]].arrival_time <= sched_clock &&
                                (!found || job_ring[i][ring_head[i]].ticket_count < least)) begin
                                least = job_ring[i][ring_head[i]].ticket_count;
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                        n_shortest++;
                    end
                    job = job_ring[pick][ring_head[pick]];
                    ring_head[pick]  = (ring_head[pick] + 1) % LINE_DEPTH;
                    ring_count[pick]--;
                    total = 64'(sched_clock) + 64'(cfg_base)
                          + 64'(cfg_per_ticket) * 64'(job.ticket_count);
                    if (total > CLK_SAT) total = CLK_SAT;
                    sched_clock     = total[CLK_W-1:0];
                    res.served_line = LINE_W'(pick + 1);
                    res.leave_time  = sched_clock;
                end
            end
            REQ_CLR: sched_clock = '0;
            default: ;
        endcase
        pending_outcomes.push_back(res);
    endtask

    // One transaction on the input side; called at a rising edge.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_requests++;
        predict_outcome(req);
    endtask

    function automatic t_in_item make_request(input logic [REQ_W-1:0] kind,
                                              input logic [ARR_W-1:0] arr,
                                              input logic [LINE_W-1:0] line,
                                              input logic [TIX_W-1:0] tix);
        t_in_item r;
        r.req_type     = kind;
        r.arrival_time = arr;
        r.line_number  = line;
        r.ticket_count = tix;
        return r;
    endfunction

    // Mostly enqueues near the current clock and serves, with some noise.
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned roll;
        longint      near;
        longint      span;
        roll = $urandom_range(99);
        r.req_type     = REQ_SERVE;
        r.arrival_time = ARR_W'($urandom);
        r.line_number  = LINE_W'($urandom);
        r.ticket_count = TIX_W'($urandom);
        if (roll < 54) begin
            r.req_type    = REQ_ENQ;
            r.line_number = LINE_W'($urandom_range(NUM_LINES, 1));
            if ($urandom_range(99) < 80) begin
                span = longint'(cfg_base) + longint'(cfg_per_ticket) * 600 + 500;
                near = longint'(sched_clock) + longint'($urandom_range(2 * span)) - span;
                if (near < 0) near = 0;
                if (near > longint'(ARR_MAX)) near = longint'(ARR_MAX);
                r.arrival_time = near[ARR_W-1:0];
            end
            // small counts make ticket ties common
            if ($urandom_range(99) < 60) r.ticket_count = TIX_W'($urandom_range(15));
        end else if (roll < 94) begin
            r.req_type = REQ_SERVE;
        end else if (roll < 96) begin
            r.req_type = REQ_CLR;
        end else if (roll < 98) begin
            r.req_type    = REQ_ENQ;
            r.line_number = ($urandom_range(1) == 0) ? LINE_W'(0)
                          : LINE_W'($urandom_range(15, NUM_LINES + 1));
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    // Drops valid and waits until every expected result has come back.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic load_service_times(input logic [CFG_W-1:0] base,
                                      input logic [CFG_W-1:0] per_ticket);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        cfg_base    = base[BASE_W-1:0];
        i_cfg_idx   <= CFG_PTT;
        i_cfg_wdata <= per_ticket;
        @(posedge i_clk);
        cfg_per_ticket = per_ticket[PTT_W-1:0];
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_corner_requests();
        send_request(make_request(REQ_UNUSED, ARR_MAX, 4'hF, TIX_MAX));
        send_request(make_request(REQ_SERVE, '0, '0, '0));
        send_request(make_request(REQ_CLR, ARR_MAX, 4'd3, TIX_MAX));
        send_request(make_request(REQ_ENQ, ARR_MAX, 4'd0, TIX_MAX));
        send_request(make_request(REQ_ENQ, ARR_MAX, 4'd13, TIX_MAX));
        send_request(make_request(REQ_ENQ, 30'd5, 4'd14, 10'd1));
        send_request(make_request(REQ_ENQ, 30'd5, 4'd15, 10'd1));
        send_request(make_request(REQ_ENQ, ARR_MAX, 4'd12, TIX_MAX));
        send_request(make_request(REQ_ENQ, '0, 4'd1, '0));
        send_request(make_request(REQ_SERVE, '0, '0, '0));
        send_request(make_request(REQ_SERVE, '0, '0, '0));
        send_request(make_request(REQ_CLR, '0, '0, '0));
        // equal arrivals: lowest line wins
        send_request(make_request(REQ_ENQ, 30'd100, 4'd5, 10'd4));
        send_request(make_request(REQ_ENQ, 30'd100, 4'd3, 10'd9));
        send_request(make_request(REQ_SERVE, '0, '0, '0));
        // clock now past the heads: fewest tickets, tie on lowest line,
        // arrival equal to the clock counts, later arrival does not
        send_request(make_request(REQ_ENQ, 30'd50, 4'd7, 10'd4));
        send_request(make_request(REQ_ENQ, 30'd210, 4'd2, 10'd4));
        send_request(make_request(REQ_ENQ, 30'd211, 4'd4, 10'd0));
        send_request(make_request(REQ_ENQ, 30'd60, 4'd11, 10'd1022));
        repeat (6) send_request(make_request(REQ_SERVE, '0, '0, '0));
    endtask

    task automatic test_full_line();
        for (int i = 0; i <= LINE_DEPTH; i++)
            send_request(make_request(REQ_ENQ, ARR_W'($urandom_range(5000)), 4'd9,
                                      TIX_W'($urandom)));
        repeat (LINE_DEPTH + 1) send_request(make_request(REQ_SERVE, '0, '0, '0));
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        stall_req = 1'b1;
        repeat (30) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct,
                                       input logic [CFG_W-1:0] base,
                                       input logic [CFG_W-1:0] per_ticket);
        wait_until_drained();
        load_service_times(base, per_ticket);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        for (int i = 0; i < NUM_LINES; i++) begin
            ring_head[i]  = 0;
            ring_count[i] = 0;
        end
        send_idle_pct = 24;
        recv_idle_pct = 47;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_requests();
        test_full_line();
        test_random_traffic(500, 24, 47, '0, '0);
        test_backpressure();
        test_random_traffic(500, 47, 24, 16'hFFFF, 16'h00FF);
        test_random_traffic(520, 0, 0, CFG_W'($urandom), CFG_W'($urandom));

        wait_until_drained();
        repeat (2 * NUM_LINES + 10) @(posedge i_clk);
        $display("Covered %0d requests with %0d results under %0d register settings.",
                 n_requests, n_results, n_settings);
        $display("Served %0d (%0d idle jumps, %0d fewest-ticket picks), %0d empty, %0d rejected.",
                 n_served, n_jumps, n_shortest, n_empty, n_rejected);
        if (n_errors == 0) begin
            $display("** multi_queue_shortest_job_server: PASSED **");
        end else begin
            $display("** multi_queue_shortest_job_server: FAILED **");
        end
        $finish;
    end

endmodule
